>>> design/hex_message_frame_decoder_macros.svh
// assertion macros for the hex message frame decoder
// no dependencies; included by the files that carry assertions
`ifndef HEX_MESSAGE_FRAME_DECODER_MACROS_SVH
`define HEX_MESSAGE_FRAME_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define HMFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// expression must never be true outside reset
`define HMFD_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define HMFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define HMFD_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

>>> design/hmfd_pkg.sv
// shared types and codes for the hex message frame decoder
// no dependencies; used by hmfd_step and hex_message_frame_decoder
`default_nettype none

package hmfd_pkg;

    localparam int CHAR_W = 8;
    localparam int BYTE_W = 8;
    localparam int ROLE_W = 2;
    localparam int PHASE_W = 3;
    localparam int DIGIT_W = 4;

    localparam logic [CHAR_W-1:0] DEFAULT_SEPARATOR = 8'd44;

    localparam logic [PHASE_W-1:0] PH_SEEK = 3'd0;
    localparam logic [PHASE_W-1:0] PH_TYPE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PAY  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE = 3'd4;

    localparam logic [ROLE_W-1:0] ROLE_TYPE    = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_LENGTH  = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 2'd2;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               second_digit_due;
        logic [DIGIT_W-1:0] held_high_digit;
        logic [BYTE_W-1:0]  payload_remaining;
    } hmfd_state_t;

    typedef struct packed {
        logic              have;
        logic [BYTE_W-1:0] byte_value;
        logic [ROLE_W-1:0] byte_role;
        logic              msg_last;
        logic              decode_error;
    } hmfd_result_t;

endpackage

`default_nettype wire

>>> design/hmfd_step.sv
// per-character decode step: next parse state and optional result
// depends on hmfd_pkg
`default_nettype none

module hmfd_step (
    input  wire logic [hmfd_pkg::CHAR_W-1:0] char_in,
    input  wire logic                        frame_end,
    input  wire logic [hmfd_pkg::CHAR_W-1:0] separator_char,
    input  wire hmfd_pkg::hmfd_state_t       state_cur,
    output hmfd_pkg::hmfd_state_t            state_next,
    output hmfd_pkg::hmfd_result_t           result
);
    import hmfd_pkg::*;

    logic               digit_ok;
    logic [DIGIT_W-1:0] digit;
    logic [BYTE_W-1:0]  pair_value;
    logic [BYTE_W-1:0]  remaining_dec;
    hmfd_state_t        st;
    hmfd_result_t       res;

    // ascii hex digit decode: 0-9, A-F, a-f
    always_comb begin
        digit_ok = 1'b0;
        digit    = '0;
        if (char_in >= 8'h30 && char_in <= 8'h39) begin
            digit_ok = 1'b1;
            digit    = DIGIT_W'(char_in - 8'h30);
        end else if (char_in >= 8'h41 && char_in <= 8'h46) begin
            digit_ok = 1'b1;
            digit    = DIGIT_W'(char_in - 8'h37);
        end else if (char_in >= 8'h61 && char_in <= 8'h66) begin
            digit_ok = 1'b1;
            digit    = DIGIT_W'(char_in - 8'h57);
        end
    end

    // bad second digit keeps the first digit alone
    assign pair_value    = digit_ok ? {state_cur.held_high_digit, digit}
                                    : {4'd0, state_cur.held_high_digit};
    assign remaining_dec = state_cur.payload_remaining - 8'd1;

    always_comb begin
        st  = state_cur;
        res = '0;

        case (state_cur.phase)
            PH_SEEK: begin
                if (char_in == separator_char) begin
                    st.phase            = PH_TYPE;
                    st.second_digit_due = 1'b0;
                end
            end
            PH_TYPE, PH_LEN, PH_PAY: begin
                res.byte_role = ROLE_W'(state_cur.phase - PH_TYPE);
                if (!state_cur.second_digit_due) begin
                    if (!digit_ok) begin
                        res.have         = 1'b1;
                        res.decode_error = 1'b1;
                        st.phase         = PH_DONE;
                    end else begin
                        st.held_high_digit  = digit;
                        st.second_digit_due = 1'b1;
                    end
                end else begin
                    st.second_digit_due = 1'b0;
                    st.held_high_digit  = '0;
                    res.have            = 1'b1;
                    res.byte_value      = pair_value;
                    if (state_cur.phase == PH_TYPE) begin
                        st.phase = PH_LEN;
                    end else if (state_cur.phase == PH_LEN) begin
                        st.payload_remaining = pair_value;
                        if (pair_value == '0) begin
                            res.msg_last = 1'b1;
                            st.phase     = PH_DONE;
                        end else begin
                            st.phase = PH_PAY;
                        end
                    end else begin
                        st.payload_remaining = remaining_dec;
                        if (remaining_dec == '0) begin
                            res.msg_last = 1'b1;
                            st.phase     = PH_DONE;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // frame end: an unfinished or unstarted message becomes an error, state restarts
        if (frame_end) begin
            if (st.phase == PH_SEEK || st.phase == PH_TYPE ||
                st.phase == PH_LEN || st.phase == PH_PAY) begin
                res.have         = 1'b1;
                res.decode_error = 1'b1;
                res.byte_role    = (st.phase == PH_SEEK) ? ROLE_TYPE
                                                         : ROLE_W'(st.phase - PH_TYPE);
            end
            st.phase             = PH_SEEK;
            st.second_digit_due  = 1'b0;
            st.held_high_digit   = '0;
            st.payload_remaining = '0;
        end

        if (res.decode_error) begin
            res.byte_value = '0;
            res.msg_last   = 1'b0;
        end
    end

    assign state_next = st;
    assign result     = res;

endmodule

`default_nettype wire

>>> design/hex_message_frame_decoder.sv
// top level of the hex message frame decoder: input register, step logic, result register
// depends on hmfd_pkg, hmfd_step and hex_message_frame_decoder_macros.svh
//
//   channel  dir  tdata               tuser                          tlast
//   s_       in   [7:0] char_in       -                              frame_end
//   m_       out  [7:0] byte_value    [1:0] byte_role, [2] error     msg_last
//   cfg_     in   [7:0] separator     -                              -
//
// one character per cycle unless m_ stalls; an accepted character's result, if any,
// goes from the input register to the result register. the input register advances
// when the result register is empty or being taken; only a stalled m_ side holds s_tready low.
// reset: synchronous active-low aresetn clears the parse state, both valid flags
// and sets the separator to a comma.
`default_nettype none

`include "hex_message_frame_decoder_macros.svh"

module hex_message_frame_decoder (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] char_in
    input  wire logic                        s_tlast,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] byte_value
    output logic [2:0]                       m_tuser,   // [1:0] byte_role, [2] decode_error
    output logic                             m_tlast,
    input  wire logic                        cfg_we,
    input  wire logic [hmfd_pkg::CHAR_W-1:0] cfg_wdata
);
    import hmfd_pkg::*;

    logic [CHAR_W-1:0] separator_reg;
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    hmfd_state_t       state_reg;
    hmfd_state_t       state_next;
    hmfd_result_t      step_res;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_value_reg;
    logic [ROLE_W-1:0] out_role_reg;
    logic              out_last_reg;
    logic              out_error_reg;
    logic              advance;
    logic              err_out;
    logic              frame_done;
    logic              state_clear;
    logic              pipe_stalled;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            separator_reg <= DEFAULT_SEPARATOR;
        end else if (cfg_we) begin
            separator_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    hmfd_step u_step (
        .char_in        (in_char_reg),
        .frame_end      (in_last_reg),
        .separator_char (separator_reg),
        .state_cur      (state_reg),
        .state_next     (state_next),
        .result         (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_SEEK, second_digit_due: 1'b0,
                           held_high_digit: '0, payload_remaining: '0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step_res.have;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_res.have) begin
            out_value_reg <= step_res.byte_value;
            out_role_reg  <= step_res.byte_role;
            out_last_reg  <= step_res.msg_last;
            out_error_reg <= step_res.decode_error;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {out_error_reg, out_role_reg};
    assign m_tlast  = out_last_reg;

    assign err_out      = m_tvalid && out_error_reg;
    assign frame_done   = advance && in_last_reg;
    assign state_clear  = (state_reg.phase == PH_SEEK) && (state_reg.payload_remaining == '0);
    assign pipe_stalled = in_valid_reg && out_valid_reg && !m_tready;

    `HMFD_NEVER(a_err_not_last, aclk, aresetn, err_out && out_last_reg, "error marked last")
    `HMFD_NEVER(a_err_value, aclk, aresetn, err_out && (out_value_reg != '0), "error with value")
    `HMFD_NEVER(a_role_code, aclk, aresetn, m_tvalid && (out_role_reg == 2'd3), "bad byte role")
    `HMFD_ASSERT(a_frame_restart, aclk, aresetn, frame_done |=> state_clear, "no frame restart")
    `HMFD_ASSERT(a_stall_cause, aclk, aresetn, !s_tready |-> pipe_stalled, "input stall")

endmodule

`default_nettype wire
